FILE: hw/rtl/square_matrix_rotate_90_macros.svh
// Assertion helpers for the RTL, used by smr_back; every use expects clk and arst_n in scope.
`ifndef SQUARE_MATRIX_ROTATE_90_MACROS_SVH
`define SQUARE_MATRIX_ROTATE_90_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/smr_pkg.sv
package smr_pkg;

	localparam int MAX_EDGE    = 8;
	localparam int DATA_W      = 32;
	localparam int EDGE_W      = 4;
	localparam int IDX_W       = $clog2(MAX_EDGE);
	localparam int SLOT_W      = $clog2(MAX_EDGE * MAX_EDGE);
	localparam int CNT_W       = SLOT_W + 1;
	localparam int NUM_BANKS   = 2;
	localparam int BANK_W      = $clog2(NUM_BANKS);
	localparam int QCNT_W      = $clog2(NUM_BANKS + 1);
	localparam int ADDR_W      = BANK_W + SLOT_W;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	// Register index is paddr[2]; only edge_size exists.
	localparam logic REG_EDGE_SIZE = 1'b0;
	localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(MAX_EDGE);

	// One loaded matrix waiting for read-out; its bank is the queue slot.
	typedef struct packed {
		logic [EDGE_W-1:0] side;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic              full;
		logic              empty;
		logic [BANK_W-1:0] wr_bank;
		logic [BANK_W-1:0] rd_bank;
	} jobq_stat_t;

	// Zero reads as one, anything above MAX_EDGE saturates.
	function automatic logic [EDGE_W-1:0] clamp_edge(input logic [EDGE_W-1:0] raw);
		logic [EDGE_W-1:0] res;
		res = raw;
		if (raw == '0) begin
			res = EDGE_W'(1);
		end else if (raw > EDGE_W'(MAX_EDGE)) begin
			res = EDGE_W'(MAX_EDGE);
		end
		return res;
	endfunction

endpackage

FILE: hw/rtl/square_matrix_rotate_90.sv
// Rotates an n-by-n matrix of signed 32-bit elements (n = edge_size, 1..8; zero acts
// as 1, larger values as 8) by 90 degrees clockwise. Elements enter row-major, one
// per cycle, into one of two banks of a 128-entry RAM; after the n*n-th element the
// loaded bank is queued and a new matrix can load into the other bank at once. The
// rotated matrix leaves row-major, one element per cycle from the RAM read port
// while out_ready is high, out_last on its final element. With both banks busy,
// elem_ready stays low until the last read of the oldest queued matrix is issued.
// Writing edge_size drops a partly loaded matrix; write it only while idle.
module square_matrix_rotate_90 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [smr_pkg::PADDR_W-1:0]   paddr,
	input  logic [smr_pkg::PDATA_W-1:0]   pwdata,
	output logic [smr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          elem_valid,
	output logic                          elem_ready,
	input  logic signed [smr_pkg::DATA_W-1:0] elem_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [smr_pkg::DATA_W-1:0] out_value,
	output logic                          out_last
);

	logic [smr_pkg::EDGE_W-1:0] edge_size_q;
	logic [smr_pkg::EDGE_W-1:0] side;
	logic                       reg_sel;
	logic                       cfg_wr;

	smr_pkg::jobq_stat_t        qstat;
	smr_pkg::job_t              push_job;
	smr_pkg::job_t              head;
	logic                       push;
	logic                       pop;
	logic                       ram_we;
	logic [smr_pkg::ADDR_W-1:0] ram_waddr;
	logic [smr_pkg::DATA_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [smr_pkg::ADDR_W-1:0] ram_raddr;
	logic [smr_pkg::DATA_W-1:0] ram_rdata;
	logic [smr_pkg::DATA_W-1:0] out_bits;

	// Register decode; a write to edge_size also restarts the load
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == smr_pkg::REG_EDGE_SIZE);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ? smr_pkg::PDATA_W'(edge_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_size_q <= smr_pkg::EDGE_RESET;
		end else if (cfg_wr) begin
			edge_size_q <= pwdata[smr_pkg::EDGE_W-1:0];
		end
	end

	assign side = smr_pkg::clamp_edge(edge_size_q);

	smr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem_value (elem_value),
		.side       (side),
		.restart    (cfg_wr),
		.qstat      (qstat),
		.push       (push),
		.push_job   (push_job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	smr_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	smr_ram #(
		.WIDTH (smr_pkg::DATA_W),
		.DEPTH (smr_pkg::RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	smr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_bits),
		.out_last  (out_last)
	);

	assign out_value = out_bits;

endmodule

FILE: hw/rtl/smr_ram.sv
module smr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/smr_jobq.sv
module smr_jobq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  smr_pkg::job_t       push_job,
	input  logic                pop,
	output smr_pkg::job_t       head,
	output smr_pkg::jobq_stat_t stat
);

	smr_pkg::job_t                     slot_q [smr_pkg::NUM_BANKS];
	logic [smr_pkg::BANK_W-1:0]        wr_q;
	logic [smr_pkg::BANK_W-1:0]        rd_q;
	logic [smr_pkg::QCNT_W-1:0]        cnt_q;

	assign head          = slot_q[rd_q];
	assign stat.full     = (cnt_q == smr_pkg::QCNT_W'(smr_pkg::NUM_BANKS));
	assign stat.empty    = (cnt_q == '0);
	assign stat.wr_bank  = wr_q;
	assign stat.rd_bank  = rd_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + smr_pkg::BANK_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + smr_pkg::BANK_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + smr_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - smr_pkg::QCNT_W'(1);
			end
		end
	end

	// Hold job descriptors
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

FILE: hw/rtl/smr_front.sv
module smr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         elem_valid,
	output logic                         elem_ready,
	input  logic [smr_pkg::DATA_W-1:0]   elem_value,
	input  logic [smr_pkg::EDGE_W-1:0]   side,
	input  logic                         restart,
	input  smr_pkg::jobq_stat_t          qstat,
	output logic                         push,
	output smr_pkg::job_t                push_job,
	output logic                         ram_we,
	output logic [smr_pkg::ADDR_W-1:0]   ram_waddr,
	output logic [smr_pkg::DATA_W-1:0]   ram_wdata
);

	logic [smr_pkg::CNT_W-1:0] load_count_q;
	logic [smr_pkg::CNT_W-1:0] count_next;
	logic [smr_pkg::CNT_W-1:0] total;
	logic                      accept;

	// Take elements while a bank is free
	assign elem_ready = !qstat.full;
	assign accept     = elem_valid && elem_ready;

	assign total      = smr_pkg::CNT_W'(side) * smr_pkg::CNT_W'(side);
	assign count_next = load_count_q + smr_pkg::CNT_W'(1);

	// Store into the bank being filled
	assign ram_we    = accept;
	assign ram_waddr = {qstat.wr_bank, load_count_q[smr_pkg::SLOT_W-1:0]};
	assign ram_wdata = elem_value;

	// Hand the full matrix to the back end
	assign push          = accept && (count_next == total);
	assign push_job.side = side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (restart || push) begin
			load_count_q <= '0;
		end else if (accept) begin
			load_count_q <= count_next;
		end
	end

endmodule

FILE: hw/rtl/smr_back.sv
`include "square_matrix_rotate_90_macros.svh"

module smr_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  smr_pkg::job_t                head,
	input  smr_pkg::jobq_stat_t          qstat,
	output logic                         pop,
	output logic                         ram_re,
	output logic [smr_pkg::ADDR_W-1:0]   ram_raddr,
	input  logic [smr_pkg::DATA_W-1:0]   ram_rdata,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [smr_pkg::DATA_W-1:0]   out_value,
	output logic                         out_last
);

	logic [smr_pkg::IDX_W-1:0]    r_q;
	logic [smr_pkg::IDX_W-1:0]    c_q;
	logic [smr_pkg::EDGE_W-1:0]   nm1;
	logic [smr_pkg::EDGE_W-1:0]   rev;
	logic [2*smr_pkg::EDGE_W-1:0] prod;
	logic [smr_pkg::SLOT_W-1:0]   slot;
	logic                         row_end;
	logic                         last_pos;
	logic                         issue;
	logic                         drain;
	logic [1:0]                   occ;

	logic                         rd_v_s1;
	logic                         last_s1;
	logic                         out_v_q;
	logic [smr_pkg::DATA_W-1:0]   out_value_q;
	logic                         out_last_q;
	logic                         skid_v_q;
	logic [smr_pkg::DATA_W-1:0]   skid_value_q;
	logic                         skid_last_q;

	// Source index (n-1-c)*n + r in the bank being drained
	assign nm1      = head.side - smr_pkg::EDGE_W'(1);
	assign rev      = nm1 - smr_pkg::EDGE_W'(c_q);
	assign prod     = rev * head.side;
	assign slot     = prod[smr_pkg::SLOT_W-1:0] + smr_pkg::SLOT_W'(r_q);
	assign row_end  = (c_q == nm1[smr_pkg::IDX_W-1:0]);
	assign last_pos = row_end && (r_q == nm1[smr_pkg::IDX_W-1:0]);

	// Issue a read only when a landing slot is guaranteed
	assign drain = out_v_q && out_ready;
	assign occ   = 2'(out_v_q) + 2'(skid_v_q) + 2'(rd_v_s1);
	assign issue = !qstat.empty && ((occ - 2'(drain)) < 2'd2);

	assign ram_re    = issue;
	assign ram_raddr = {qstat.rd_bank, slot};
	assign pop       = issue && last_pos;

	// Walk the result in row-major order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (issue) begin
			if (row_end) begin
				c_q <= '0;
				r_q <= last_pos ? '0 : r_q + smr_pkg::IDX_W'(1);
			end else begin
				c_q <= c_q + smr_pkg::IDX_W'(1);
			end
		end
	end

	// Track read-in-flight, output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1  <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (!out_v_q || drain) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= rd_v_s1;
				end else begin
					out_v_q <= rd_v_s1;
				end
			end else if (rd_v_s1) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	// Move payload along the same paths
	always_ff @(posedge clk) begin
		last_s1 <= last_pos;
		if (!out_v_q || drain) begin
			if (skid_v_q) begin
				out_value_q  <= skid_value_q;
				out_last_q   <= skid_last_q;
				skid_value_q <= ram_rdata;
				skid_last_q  <= last_s1;
			end else begin
				out_value_q <= ram_rdata;
				out_last_q  <= last_s1;
			end
		end else if (rd_v_s1) begin
			skid_value_q <= ram_rdata;
			skid_last_q  <= last_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

	`SMR_ASSERT_IMP(a_skid_behind_out, skid_v_q, out_v_q, "skid holds data with output empty")
	`SMR_ASSERT_IMP(a_no_overfill, skid_v_q, !rd_v_s1, "read landed with both slots full")
	`SMR_ASSERT_NXT(a_walk_restarts, pop, (r_q == '0) && (c_q == '0), "walk did not restart")

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import smr_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int RANDOM_ITEMS   = 320;
	localparam int REPORT_MAX     = 10;
	localparam int STORE_SLOTS    = MAX_EDGE * MAX_EDGE;
	localparam int EDGE_SIZE_IDX  = int'(REG_EDGE_SIZE);
	localparam int SPARE_IDX      = 1;
	localparam int PRESSURE_PHASE = 3;

	// Receiver stall patterns
	localparam int RX_OPEN   = 0;
	localparam int RX_COIN   = 1;
	localparam int RX_SPARSE = 2;
	localparam int RX_BEAT   = 3;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} rot_elem_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [PADDR_W-1:0]         paddr = '0;
	logic [PDATA_W-1:0]         pwdata = '0;
	logic [PDATA_W-1:0]         prdata;
	logic                       pready;
	logic                       elem_valid = 1'b0;
	logic                       elem_ready;
	logic signed [DATA_W-1:0]   elem_value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [DATA_W-1:0]   out_value;
	logic                       out_last;

	// Predictor state: edge register, load position and the source matrix
	logic [EDGE_W-1:0]          side_reg = EDGE_RESET;
	logic signed [DATA_W-1:0]   src_store [STORE_SLOTS];
	int unsigned                load_count = 0;
	rot_elem_t                  rotated_expect [$];
	rot_elem_t                  want_elem;
	logic signed [DATA_W-1:0]   pending_elems [$];

	int                         mismatches = 0;
	int unsigned                idle_cycles = 0;
	int                         burst_left = 0;
	int                         gap_left = 0;
	int                         rx_mode = RX_OPEN;
	int                         rx_left = 0;
	logic [7:0]                 rx_tick = '0;
	int                         holdoff_left = 0;
	logic                       pressure_req = 1'b0;
	logic                       pressure_done = 1'b0;

	square_matrix_rotate_90 uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.elem_valid (elem_valid),
		.elem_ready (elem_ready),
		.elem_value (elem_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (out_value),
		.out_last   (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Zero acts as one, anything above the maximum saturates
	function automatic int unsigned side_in_use(input logic [EDGE_W-1:0] raw);
		int unsigned n;
		n = raw;
		if (n == 0) begin
			n = 1;
		end else if (n > MAX_EDGE) begin
			n = MAX_EDGE;
		end
		return n;
	endfunction

	// Store one source element; on the last one of the matrix queue the rotated matrix
	function automatic void absorb_elem(input logic signed [DATA_W-1:0] v);
		int unsigned n;
		int unsigned total;
		int unsigned r;
		int unsigned c;
		rot_elem_t e;
		n = side_in_use(side_reg);
		total = n * n;
		src_store[load_count % STORE_SLOTS] = v;
		load_count = (load_count + 1) & 32'h7F;
		if (load_count < total) begin
			return;
		end
		load_count = 0;
		for (r = 0; r < n; r++) begin
			for (c = 0; c < n; c++) begin
				e.value = src_store[((n - 1 - c) * n + r) % STORE_SLOTS];
				e.last = (r == n - 1) && (c == n - 1);
				rotated_expect.push_back(e);
			end
		end
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			$display("mismatch: %s", what);
		end
	endfunction

	// Random words half the time, else the extremes, all ones or small values
	function automatic logic signed [DATA_W-1:0] pick_elem();
		case ($urandom_range(0, 7))
			0: return {1'b0, {(DATA_W - 1){1'b1}}};
			1: return {1'b1, {(DATA_W - 1){1'b0}}};
			2: return '1;
			3: return DATA_W'($urandom_range(0, 31)) - DATA_W'(16);
			default: return $urandom;
		endcase
	endfunction

	// One APB access; update the predictor at the edge where a write lands
	task automatic reg_access(input bit wr, input int idx, input logic [PDATA_W-1:0] wdata,
		output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= PADDR_W'(idx * 4);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		if (wr && idx == EDGE_SIZE_IDX) begin
			side_reg = wdata[EDGE_W-1:0];
			load_count = 0;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every request is taken and every result is in, then let the block go quiet
	task automatic settle();
		while (pending_elems.size() != 0 || elem_valid || rotated_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_valid <= 1'b0;
			elem_value <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!elem_valid || elem_ready) begin
			if (gap_left > 0) begin
				elem_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_elems.size() > 0) begin
				elem_valid <= 1'b1;
				elem_value <= pending_elems.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				elem_valid <= 1'b0;
			end
		end
	end

	// Receiver: switch among stall patterns; hold off once for a long stretch on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode <= RX_OPEN;
			rx_left <= 0;
			rx_tick <= '0;
			holdoff_left <= 0;
			pressure_done <= 1'b0;
		end else begin
			rx_tick <= rx_tick + 8'd1;
			if (holdoff_left > 0) begin
				out_ready <= 1'b0;
				holdoff_left <= holdoff_left - 1;
			end else if (pressure_req && !pressure_done) begin
				out_ready <= 1'b0;
				holdoff_left <= HOLDOFF_CYCLES;
				pressure_done <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_mode <= $urandom_range(RX_OPEN, RX_BEAT);
					rx_left <= $urandom_range(16, 160);
				end else begin
					rx_left <= rx_left - 1;
				end
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= $urandom_range(0, 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= rx_tick[2];
				endcase
			end
		end
	end

	// Predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (elem_valid && elem_ready) begin
				absorb_elem(elem_value);
			end
			if (out_valid && out_ready) begin
				if (rotated_expect.size() == 0) begin
					note_mismatch($sformatf("unexpected result value %0d last %0b",
						out_value, out_last));
				end else begin
					want_elem = rotated_expect.pop_front();
					if (out_value !== want_elem.value || out_last !== want_elem.last) begin
						note_mismatch($sformatf("expected value %0d last %0b, got value %0d last %0b",
							want_elem.value, want_elem.last, out_value, out_last));
					end
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		if (!arst_n || (elem_valid && elem_ready) || (out_valid && out_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [PDATA_W-1:0] rd;
		int unsigned issued;
		int unsigned phase;
		int unsigned n;
		int unsigned mats;
		logic [EDGE_W-1:0] cfg;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge register must come out of reset at the maximum
		reg_access(1'b0, EDGE_SIZE_IDX, '0, rd);
		if (rd !== PDATA_W'(EDGE_RESET)) begin
			note_mismatch($sformatf("edge_size after reset: expected %0d, got %0d",
				EDGE_RESET, rd));
		end

		// One-element matrix: pass extremes straight through
		reg_access(1'b1, EDGE_SIZE_IDX, 1, rd);
		pending_elems.push_back({1'b0, {(DATA_W - 1){1'b1}}});
		pending_elems.push_back({1'b1, {(DATA_W - 1){1'b0}}});
		pending_elems.push_back('0);
		pending_elems.push_back('1);
		settle();

		// Edge of zero acts as one
		reg_access(1'b1, EDGE_SIZE_IDX, 0, rd);
		pending_elems.push_back(32'h5555_5555);
		pending_elems.push_back(32'hAAAA_AAAA);
		settle();

		// Smallest real rotation
		reg_access(1'b1, EDGE_SIZE_IDX, 2, rd);
		pending_elems.push_back(1);
		pending_elems.push_back(-2);
		pending_elems.push_back({1'b0, {(DATA_W - 1){1'b1}}});
		pending_elems.push_back({1'b1, {(DATA_W - 1){1'b0}}});
		settle();

		// Edge write drops a partly loaded matrix
		reg_access(1'b1, EDGE_SIZE_IDX, 3, rd);
		repeat (4) pending_elems.push_back(pick_elem());
		settle();
		reg_access(1'b1, EDGE_SIZE_IDX, 2, rd);
		repeat (4) pending_elems.push_back(pick_elem());
		settle();

		// Write to a missing register leaves the partial load alone
		repeat (2) pending_elems.push_back(pick_elem());
		settle();
		reg_access(1'b1, SPARE_IDX, '1, rd);
		repeat (2) pending_elems.push_back(pick_elem());
		settle();

		// Random phases: whole matrices at each edge, sometimes a dropped partial load
		issued = 0;
		phase = 0;
		while (issued < RANDOM_ITEMS) begin
			case (phase)
				0: cfg = 15;
				1: cfg = 1;
				2: cfg = 0;
				PRESSURE_PHASE: cfg = 4;
				4: cfg = 9;
				5: cfg = 8;
				6: cfg = 3;
				default: cfg = $urandom_range(0, 15);
			endcase
			reg_access(1'b1, EDGE_SIZE_IDX, cfg, rd);
			n = side_in_use(cfg);
			if (phase == PRESSURE_PHASE) begin
				mats = 6;
				pressure_req <= 1'b1;
			end else if (n <= 2) begin
				mats = $urandom_range(3, 10);
			end else if (n <= 5) begin
				mats = $urandom_range(1, 4);
			end else begin
				mats = $urandom_range(1, 2);
			end
			// Keep the total near the planned count
			while (phase != PRESSURE_PHASE && mats > 1 && issued + mats * n * n > RANDOM_ITEMS) begin
				mats--;
			end
			repeat (mats * n * n) pending_elems.push_back(pick_elem());
			issued += mats * n * n;
			if (n > 1 && $urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, n * n - 1)) pending_elems.push_back(pick_elem());
			end
			settle();
			phase++;
		end

		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
